// File: rtl/lbachs_pkg.sv
package lbachs_pkg;

  localparam int unsigned BLK_W      = 32;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned SPT_W      = 6;
  localparam int unsigned HEAD_W     = 9;
  localparam int unsigned CYL_W      = 11;
  localparam int unsigned CYL_OUT_W  = 10;
  localparam int unsigned HD_OUT_W   = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam int unsigned MAX_CHUNK_DEF   = 8;
  localparam int unsigned MAX_REQUEST_DEF = 64;
  localparam int unsigned HW_CHUNK_CAP    = 127;

  localparam logic [SPT_W-1:0]  SPT_RST   = SPT_W'(63);
  localparam logic [HEAD_W-1:0] HEADS_RST = HEAD_W'(16);
  localparam logic [CYL_W-1:0]  CYLS_RST  = CYL_W'(1024);
  localparam logic [HEAD_W-1:0] HEADS_MAX = HEAD_W'(256);
  localparam logic [CYL_W-1:0]  CYLS_MAX  = CYL_W'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SECTORS_PER_TRACK = 2'd0,
    CFG_HEAD_COUNT        = 2'd1,
    CFG_CYLINDER_COUNT    = 2'd2
  } cfg_idx_e;

endpackage

// File: rtl/lbachs_req_if.sv
interface lbachs_req_if;
  logic                              valid;
  logic                              ready;
  logic [lbachs_pkg::BLK_W-1:0]      start_block;
  logic [lbachs_pkg::CNT_W-1:0]      sector_count;

  modport source (output valid, output start_block, output sector_count, input ready);
  modport sink   (input valid, input start_block, input sector_count, output ready);
endinterface

// File: rtl/lbachs_cmd_if.sv
interface lbachs_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [lbachs_pkg::CYL_OUT_W-1:0]  cylinder;
  logic [lbachs_pkg::HD_OUT_W-1:0]   head;
  logic [lbachs_pkg::SPT_W-1:0]      sector;
  logic [lbachs_pkg::CNT_W-1:0]      chunk_sectors;
  logic                              range_error;
  logic                              last;

  modport source (output valid, output cylinder, output head, output sector,
                  output chunk_sectors, output range_error, output last, input ready);
  modport sink   (input valid, input cylinder, input head, input sector,
                  input chunk_sectors, input range_error, input last, output ready);
endinterface

// File: rtl/lba_to_chs_request_splitter.sv
// Read request splitter: logical block address to cylinder/head/sector commands.
//
// req_i takes one beat per request (start_block, sector_count). cmd_o returns a
// run of command beats, one per chunk, the final one flagged by last. A chunk
// never crosses a track end and holds at most MAX_CHUNK sectors. A cylinder
// beyond the device gives one beat with range_error and last set; an empty
// request gives one beat with only last set.
// The user must write the geometry registers through cfg_we_i/cfg_idx_i/
// cfg_data_i only while no request is in progress; the block does not enforce it.
//
// One restoring divider, one quotient bit per cycle, is used twice per chunk
// (block by sectors per track, then track by heads); the chunk is then sized
// and the beat placed in the output register. req_i.ready is high only while
// no request is in progress. A stalled receiver holds the command beat in the
// output register and the sequencer waits. Reset returns to idle and loads the
// default geometry (63 sectors, 16 heads, 1024 cylinders).
module lba_to_chs_request_splitter #(
  parameter int unsigned MAX_CHUNK   = lbachs_pkg::MAX_CHUNK_DEF,
  parameter int unsigned MAX_REQUEST = lbachs_pkg::MAX_REQUEST_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lbachs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lbachs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  lbachs_req_if.sink                          req_i,
  lbachs_cmd_if.source                        cmd_o
);

  localparam int unsigned BW     = lbachs_pkg::BLK_W;
  localparam int unsigned CW     = lbachs_pkg::CNT_W;
  localparam int unsigned SW     = lbachs_pkg::SPT_W;
  localparam int unsigned DW     = lbachs_pkg::HEAD_W;
  localparam int unsigned YW     = lbachs_pkg::CYL_W;
  localparam int unsigned STEP_W = $clog2(BW);
  localparam int unsigned CAP    = (MAX_CHUNK < lbachs_pkg::HW_CHUNK_CAP) ?
                                   MAX_CHUNK : lbachs_pkg::HW_CHUNK_CAP;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_TRACK,
    ST_DIV_CYL,
    ST_CHUNK,
    ST_EMIT
  } state_e;

  state_e                state_q;
  logic [SW-1:0]         spt_q;
  logic [DW-1:0]         heads_q;
  logic [YW-1:0]         cyls_q;
  logic [BW-1:0]         block_q;
  logic [CW-1:0]         left_q;
  logic [BW-1:0]         quo_q;
  logic [DW-1:0]         rem_q;
  logic [DW-1:0]         div_q;
  logic [STEP_W-1:0]     step_q;
  logic [SW-1:0]         offs_q;

  logic [SW-1:0]         spt_eff;
  logic [DW-1:0]         heads_eff;
  logic [YW-1:0]         cyls_eff;
  logic [DW:0]           rem_sh;
  logic                  ge;
  logic [DW-1:0]         rem_n;
  logic [BW-1:0]         quo_n;
  logic                  cyl_over;
  logic [CW-1:0]         room;
  logic [CW-1:0]         n_cap;
  logic [CW-1:0]         n_chunk;
  logic [CW-1:0]         cnt_sat;

  assign spt_eff   = (spt_q == '0) ? SW'(1) : spt_q;
  assign heads_eff = (heads_q == '0) ? DW'(1) :
                     (heads_q > lbachs_pkg::HEADS_MAX) ? lbachs_pkg::HEADS_MAX : heads_q;
  assign cyls_eff  = (cyls_q > lbachs_pkg::CYLS_MAX) ? lbachs_pkg::CYLS_MAX : cyls_q;

  // shared restoring divider step
  assign rem_sh = {rem_q, quo_q[BW-1]};
  assign ge     = rem_sh >= {1'b0, div_q};
  assign rem_n  = ge ? DW'(rem_sh - {1'b0, div_q}) : DW'(rem_sh);
  assign quo_n  = {quo_q[BW-2:0], ge};

  assign cyl_over = (quo_q[BW-1:YW] != '0) || (quo_q[YW-1:0] >= cyls_eff);
  assign room     = CW'(spt_eff) - CW'(offs_q);
  assign n_cap    = (left_q > CW'(CAP)) ? CW'(CAP) : left_q;
  assign n_chunk  = (n_cap > room) ? room : n_cap;
  assign cnt_sat  = (req_i.sector_count > CW'(MAX_REQUEST)) ?
                    CW'(MAX_REQUEST) : req_i.sector_count;

  assign req_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spt_q   <= lbachs_pkg::SPT_RST;
      heads_q <= lbachs_pkg::HEADS_RST;
      cyls_q  <= lbachs_pkg::CYLS_RST;
    end else if (cfg_we_i) begin
      unique case (lbachs_pkg::cfg_idx_e'(cfg_idx_i))
        lbachs_pkg::CFG_SECTORS_PER_TRACK: spt_q   <= cfg_data_i[SW-1:0];
        lbachs_pkg::CFG_HEAD_COUNT:        heads_q <= cfg_data_i[DW-1:0];
        lbachs_pkg::CFG_CYLINDER_COUNT:    cyls_q  <= cfg_data_i[YW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_o.valid <= 1'b0;
      left_q      <= '0;
      step_q      <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            block_q <= req_i.start_block;
            left_q  <= cnt_sat;
            if (cnt_sat == '0) begin
              cmd_o.cylinder      <= '0;
              cmd_o.head          <= '0;
              cmd_o.sector        <= '0;
              cmd_o.chunk_sectors <= '0;
              cmd_o.range_error   <= 1'b0;
              cmd_o.last          <= 1'b1;
              cmd_o.valid         <= 1'b1;
              state_q             <= ST_EMIT;
            end else begin
              quo_q   <= req_i.start_block;
              rem_q   <= '0;
              div_q   <= DW'(spt_eff);
              step_q  <= STEP_W'(BW - 1);
              state_q <= ST_DIV_TRACK;
            end
          end
        end
        ST_DIV_TRACK: begin
          quo_q <= quo_n;
          if (step_q == '0) begin
            offs_q  <= rem_n[SW-1:0];
            rem_q   <= '0;
            div_q   <= heads_eff;
            step_q  <= STEP_W'(BW - 1);
            state_q <= ST_DIV_CYL;
          end else begin
            rem_q  <= rem_n;
            step_q <= step_q - STEP_W'(1);
          end
        end
        ST_DIV_CYL: begin
          quo_q  <= quo_n;
          rem_q  <= rem_n;
          step_q <= step_q - STEP_W'(1);
          if (step_q == '0) begin
            state_q <= ST_CHUNK;
          end
        end
        ST_CHUNK: begin
          cmd_o.valid <= 1'b1;
          state_q     <= ST_EMIT;
          if (cyl_over) begin
            cmd_o.cylinder      <= '0;
            cmd_o.head          <= '0;
            cmd_o.sector        <= '0;
            cmd_o.chunk_sectors <= '0;
            cmd_o.range_error   <= 1'b1;
            cmd_o.last          <= 1'b1;
            left_q              <= '0;
          end else begin
            cmd_o.cylinder      <= quo_q[lbachs_pkg::CYL_OUT_W-1:0];
            cmd_o.head          <= rem_q[lbachs_pkg::HD_OUT_W-1:0];
            cmd_o.sector        <= offs_q + SW'(1);
            cmd_o.chunk_sectors <= n_chunk;
            cmd_o.range_error   <= 1'b0;
            cmd_o.last          <= (left_q == n_chunk);
            left_q              <= left_q - n_chunk;
            block_q             <= block_q + BW'(n_chunk);
          end
        end
        ST_EMIT: begin
          if (cmd_o.ready) begin
            cmd_o.valid <= 1'b0;
            if (cmd_o.last) begin
              state_q <= ST_IDLE;
            end else begin
              quo_q   <= block_q;
              rem_q   <= '0;
              div_q   <= DW'(spt_eff);
              step_q  <= STEP_W'(BW - 1);
              state_q <= ST_DIV_TRACK;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.valid && cmd_o.range_error |-> cmd_o.last && cmd_o.chunk_sectors == '0)
    else $error("range error beat not final or not empty");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !cmd_o.valid)
    else $error("request taken while a command beat is pending");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.valid && cmd_o.chunk_sectors == '0 |-> cmd_o.last)
    else $error("empty command beat that is not final");

  a_left_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> left_q <= CW'(MAX_REQUEST))
    else $error("remaining count above request limit");

  a_chunk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.valid |-> cmd_o.chunk_sectors <= CW'(CAP))
    else $error("chunk larger than the chunk limit");

endmodule

// File: test/tb_lba_to_chs_request_splitter.sv
`timescale 1ns / 100ps

module tb_lba_to_chs_request_splitter;
  import lbachs_pkg::*;

  typedef struct packed {
    logic [CYL_OUT_W-1:0] cylinder;
    logic [HD_OUT_W-1:0]  head;
    logic [SPT_W-1:0]     sector;
    logic [CNT_W-1:0]     chunk_sectors;
    logic                 range_error;
    logic                 last;
  } chs_cmd_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  lbachs_req_if req_if ();
  lbachs_cmd_if cmd_if ();

  lba_to_chs_request_splitter DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req_i     (req_if),
    .cmd_o     (cmd_if)
  );

  logic [SPT_W-1:0]  spt_reg;
  logic [HEAD_W-1:0] head_reg;
  logic [CYL_W-1:0]  cyl_reg;

  chs_cmd_t pending_cmds[$];
  int       errors;
  int       tx_idle_pct;
  int       rx_stall_pct;
  int       rx_hold_cycles;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    #(200_000_000);
    $display("tb_lba_to_chs_request_splitter: errors");
    $finish;
  end

  function automatic void effective_geometry(output int unsigned spt_e,
                                             output int unsigned heads_e,
                                             output int unsigned cyls_e);
    spt_e   = (spt_reg == 0) ? 1 : spt_reg;
    heads_e = (head_reg == 0) ? 1 : ((head_reg > HEADS_MAX) ? HEADS_MAX : head_reg);
    cyls_e  = (cyl_reg > CYLS_MAX) ? CYLS_MAX : cyl_reg;
  endfunction

  function automatic void split_request(logic [BLK_W-1:0] blk, logic [CNT_W-1:0] cnt);
    int unsigned spt_e, heads_e, cyls_e, left, offs, track, n;
    logic [BLK_W-1:0] cur;
    chs_cmd_t c;
    effective_geometry(spt_e, heads_e, cyls_e);
    left = (cnt > MAX_REQUEST_DEF) ? MAX_REQUEST_DEF : cnt;
    if (left == 0) begin
      c = '0;
      c.last = 1'b1;
      pending_cmds.push_back(c);
      return;
    end
    cur = blk;
    while (left > 0) begin
      offs  = cur % spt_e;
      track = cur / spt_e;
      c = '0;
      if (track / heads_e >= cyls_e) begin
        c.range_error = 1'b1;
        c.last        = 1'b1;
        pending_cmds.push_back(c);
        left = 0;
      end else begin
        n = left;
        if (n > MAX_CHUNK_DEF) n = MAX_CHUNK_DEF;
        if (n > HW_CHUNK_CAP) n = HW_CHUNK_CAP;
        if (offs + n > spt_e) n = spt_e - offs;
        left -= n;
        c.cylinder      = CYL_OUT_W'(track / heads_e);
        c.head          = HD_OUT_W'(track % heads_e);
        c.sector        = SPT_W'(offs + 1);
        c.chunk_sectors = CNT_W'(n);
        c.last          = (left == 0);
        pending_cmds.push_back(c);
        cur = cur + BLK_W'(n);
      end
    end
  endfunction

  function automatic logic [BLK_W-1:0] pick_block();
    int unsigned s, h, c, r;
    longint unsigned cap;
    effective_geometry(s, h, c);
    cap = longint'(s) * h * c;
    r = $urandom_range(99);
    if (cap == 0 || r >= 85) return $urandom;
    if (r < 60) return BLK_W'($urandom_range(0, 32'(cap - 1)));
    if (r < 75) begin
      if (cap > 70) return BLK_W'(cap - $urandom_range(1, 70));
      return BLK_W'($urandom_range(0, 32'(cap - 1)));
    end
    return BLK_W'(($urandom_range(0, 32'(cap - 1)) / s) * s + s - 1);
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 75) return CNT_W'($urandom_range(1, 16));
    if (r < 92) return CNT_W'($urandom_range(17, 64));
    return CNT_W'($urandom_range(65, 127));
  endfunction

  // receiver: long hold-off first, then random stalls
  always @(negedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      rx_hold_cycles = rx_hold_cycles - 1;
      cmd_if.ready <= 1'b0;
    end else begin
      cmd_if.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    chs_cmd_t got, want;
    if (rst_ni && cmd_if.valid && cmd_if.ready) begin
      got = '{cmd_if.cylinder, cmd_if.head, cmd_if.sector, cmd_if.chunk_sectors,
              cmd_if.range_error, cmd_if.last};
      if (pending_cmds.size() == 0) begin
        errors++;
        $display("%0t: unexpected command beat: expected none, actual cyl %0d head %0d",
                 $time, got.cylinder, got.head,
                 " sec %0d n %0d err %0b last %0b",
                 got.sector, got.chunk_sectors, got.range_error, got.last);
      end else begin
        want = pending_cmds.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: command mismatch: expected cyl %0d head %0d sec %0d n %0d",
                   $time, want.cylinder, want.head, want.sector, want.chunk_sectors,
                   " err %0b last %0b", want.range_error, want.last);
          $display("%0t:                   actual cyl %0d head %0d sec %0d n %0d",
                   $time, got.cylinder, got.head, got.sector, got.chunk_sectors,
                   " err %0b last %0b", got.range_error, got.last);
        end
      end
    end
  end

  task automatic send_request(logic [BLK_W-1:0] blk, logic [CNT_W-1:0] cnt);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.start_block  <= blk;
    req_if.sector_count <= cnt;
    do @(posedge clk_i); while (!req_if.ready);
    split_request(blk, cnt);
    @(negedge clk_i);
  endtask

  // drop valid and hold until every expected beat is back
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    case (idx)
      CFG_SECTORS_PER_TRACK: spt_reg  = data[SPT_W-1:0];
      CFG_HEAD_COUNT:        head_reg = data[HEAD_W-1:0];
      CFG_CYLINDER_COUNT:    cyl_reg  = data[CYL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(int unsigned s, int unsigned h, int unsigned c);
    wait_idle();
    write_reg(CFG_SECTORS_PER_TRACK, CFG_DATA_W'(s));
    write_reg(CFG_HEAD_COUNT, CFG_DATA_W'(h));
    write_reg(CFG_CYLINDER_COUNT, CFG_DATA_W'(c));
    cfg_we_i <= 1'b0;
  endtask

  task automatic pick_geometry();
    int unsigned s, h, c, r;
    s = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(1, 63);
    r = $urandom_range(19);
    if (r == 0) h = 0;
    else if (r == 1) h = $urandom_range(257, 2047);
    else if (r < 5) h = $urandom_range(1, 4);
    else h = $urandom_range(1, 256);
    r = $urandom_range(19);
    if (r == 0) c = 0;
    else if (r == 1) c = $urandom_range(1025, 2047);
    else if (r < 4) c = $urandom_range(1, 4);
    else c = $urandom_range(1, 1024);
    set_geometry(s, h, c);
  endtask

  task automatic test_reset_geometry();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_request(32'd0, 7'd0);
    send_request(32'd0, 7'd1);
    send_request(32'd0, 7'd64);
    send_request(32'd0, 7'd127);
    send_request(32'd0, 7'd65);
    send_request(32'd62, 7'd8);
    send_request(32'd60, 7'd10);
    send_request(32'd1032191, 7'd1);
    send_request(32'd1032190, 7'd5);
    send_request(32'd1032192, 7'd1);
    send_request(32'hffff_ffff, 7'd64);
    send_request(32'h8000_0000, 7'd0);
    send_request(32'd5043, 7'd33);
    send_request(32'd1007, 7'd2);
    send_request(32'd12345, 7'd100);
    wait_idle();
  endtask

  task automatic test_geometry_extremes();
    set_geometry(0, 0, 0);
    send_request(32'd0, 7'd5);
    send_request(32'd7, 7'd0);
    set_geometry(1, 1, 1);
    send_request(32'd0, 7'd3);
    send_request(32'd0, 7'd1);
    set_geometry(63, 256, 1024);
    send_request(32'd16515071, 7'd64);
    send_request(32'd0, 7'd64);
    set_geometry(2047, 2047, 2047);
    send_request(32'd16515067, 7'd20);
    set_geometry(40, 257, 1025);
    send_request(32'd10485755, 7'd12);
    send_request(32'd39, 7'd9);
    wait_idle();
  endtask

  task automatic test_stalled_output();
    set_geometry(2, 16, 1024);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    @(posedge clk_i);
    rx_hold_cycles = 600;
    @(negedge clk_i);
    repeat (4) send_request(pick_block(), 7'd64);
    wait_idle();
  endtask

  task automatic test_random_traffic(int n, int tx_pct, int rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) pick_geometry();
      else if ($urandom_range(99) < 3) wait_idle();
      send_request(pick_block(), pick_count());
    end
    wait_idle();
  endtask

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CFG_SECTORS_PER_TRACK;
    cfg_data_i          = '0;
    req_if.valid        = 1'b0;
    req_if.start_block  = '0;
    req_if.sector_count = '0;
    cmd_if.ready        = 1'b0;
    spt_reg             = SPT_RST;
    head_reg            = HEADS_RST;
    cyl_reg             = CYLS_RST;
    errors              = 0;
    tx_idle_pct         = 0;
    rx_stall_pct        = 0;
    rx_hold_cycles      = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_geometry();
    test_geometry_extremes();
    test_stalled_output();
    test_random_traffic(112, 0, 0);
    test_random_traffic(112, 69, 0);
    test_random_traffic(112, 0, 69);
    test_random_traffic(112, 27, 27);

    wait_idle();
    repeat (150) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_lba_to_chs_request_splitter: clean");
    end else begin
      $display("tb_lba_to_chs_request_splitter: errors");
    end
    $finish;
  end

endmodule
